FILE: sv/hamming_sec_decoder_defines.svh
// Assertion macros for the Hamming decoder. They compile to nothing in synthesis.
`ifndef HAMMING_SEC_DECODER_DEFINES_SVH
`define HAMMING_SEC_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define HSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define HSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HSD_ASSERT(lbl, prop, msg)
`define HSD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/hsd_pkg.sv
package hsd_pkg;

    localparam int DATA_W      = 64;
    localparam int CODE_W      = 71;
    localparam int CODE_HIGH_W = 7;
    localparam int LEN_W       = 7;
    localparam int SYN_W       = 7;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    localparam logic [ST_W-1:0] ST_CLEAN   = 2'd0;
    localparam logic [ST_W-1:0] ST_FIXED   = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERRUN = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  n;
    } t_len;

    // word[j] holds codeword position j+1
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  n;
    } t_word;

    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  n;
        logic [SYN_W-1:0]  syn;
    } t_syn;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [SYN_W-1:0]  syn;
        logic [ST_W-1:0]   status;
    } t_res;

    // Fewest parity bits r with 2^r >= m + r + 1.
    function automatic logic [3:0] parity_count(input logic [LEN_W-1:0] m);
        logic [3:0] r;
        logic       done;
        r    = '0;
        done = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!done) begin
                if ((9'd1 << i) >= (9'(m) + 9'(i) + 9'd1)) begin
                    done = 1'b1;
                end else begin
                    r = r + 4'd1;
                end
            end
        end
        return r;
    endfunction

    // Word index of the k-th position that is not a power of two.
    function automatic int data_pos(input int k);
        int cnt;
        int res;
        cnt = 0;
        res = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == k) res = p - 1;
                cnt++;
            end
        end
        return res;
    endfunction

    // Word bits whose position has bit b set.
    function automatic logic [CODE_W-1:0] pos_mask(input int b);
        logic [CODE_W-1:0] mask;
        mask = '0;
        for (int j = 0; j < CODE_W; j++) begin
            mask[j] = (((j + 1) >> b) & 1) != 0;
        end
        return mask;
    endfunction

endpackage

FILE: sv/hsd_len_stage.sv
module hsd_len_stage
    import hsd_pkg::*;
#(
    parameter int MAX_DATA_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_W-1:0]      i_code_low,
    input  logic [CODE_HIGH_W-1:0] i_code_high,
    input  logic [LEN_W-1:0]       i_data_length,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_len                   o_data
);

    logic             r_valid;
    t_len             r_data;
    t_len             n_data;
    logic [LEN_W-1:0] m_sat;

    always_comb begin
        m_sat = (i_data_length > LEN_W'(MAX_DATA_BITS)) ? LEN_W'(MAX_DATA_BITS)
                                                         : i_data_length;
        n_data.code = {i_code_high, i_code_low};
        n_data.n    = m_sat + LEN_W'(parity_count(m_sat));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/hsd_align_stage.sv
module hsd_align_stage
    import hsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_len  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_data
);

    logic              r_valid;
    t_word             r_data;
    t_word             n_data;
    logic [LEN_W-1:0]  shamt;
    logic [CODE_W-1:0] shifted;

    // Move codeword bit n-1 to the top, drop bits at n and above, then reverse
    always_comb begin
        shamt   = LEN_W'(CODE_W) - i_data.n;
        shifted = i_data.code << shamt;
        for (int j = 0; j < CODE_W; j++) begin
            n_data.word[j] = shifted[CODE_W-1-j];
        end
        n_data.n = i_data.n;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/hsd_syn_stage.sv
module hsd_syn_stage
    import hsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_syn  o_data
);

    logic r_valid;
    t_syn r_data;
    t_syn n_data;

    // Positions past n are zero, so every check can run over the full word
    always_comb begin
        for (int b = 0; b < SYN_W; b++) begin
            n_data.syn[b] = ^(i_data.word & pos_mask(b));
        end
        n_data.word = i_data.word;
        n_data.n    = i_data.n;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/hsd_fix_stage.sv
module hsd_fix_stage
    import hsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_syn i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_data
);

    logic              r_valid;
    t_res              r_data;
    t_res              n_data;
    logic              nonzero;
    logic              flip;
    logic [CODE_W-1:0] fixed;

    always_comb begin
        nonzero = (i_data.syn != '0);
        flip    = nonzero && (i_data.syn <= i_data.n);
        fixed   = i_data.word;
        if (flip) begin
            fixed = i_data.word ^ (CODE_W'(1) << (i_data.syn - SYN_W'(1)));
        end
        for (int k = 0; k < DATA_W; k++) begin
            n_data.data[k] = fixed[data_pos(k)];
        end
        n_data.syn = i_data.syn;
        if (flip) begin
            n_data.status = ST_FIXED;
        end else if (nonzero) begin
            n_data.status = ST_OVERRUN;
        end else begin
            n_data.status = ST_CLEAN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/hamming_sec_decoder.sv
// Channel   Dir  Fields in tdata (lowest bit up)
// s_axis    in   code_low[63:0], code_high[70:64], data_length[77:71], zero pad
// m_axis    out  data_out[63:0], syndrome[70:64], status[72:71], zero pad
//
// One transaction per cycle sustained while m_axis_tready stays high; each one passes
// through the four register stages: length, alignment, syndrome, correction and gather.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Backpressure ripples from m_axis_tready through every stage; an empty stage
// always takes new data, so bubbles close up and nothing is dropped or repeated.
`include "hamming_sec_decoder_defines.svh"

module hamming_sec_decoder
    import hsd_pkg::*;
#(
    parameter int MAX_DATA_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // code_low[63:0], code_high[70:64], data_length[77:71]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // data_out[63:0], syndrome[70:64], status[72:71]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic  len_valid, len_ready;
    logic  aln_valid, aln_ready;
    logic  syn_valid, syn_ready;
    t_len  len_data;
    t_word aln_data;
    t_syn  syn_data;
    t_res  res_data;

    // Saturate the data length and derive the codeword length
    hsd_len_stage #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_len (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_code_low   (s_axis_tdata[DATA_W-1:0]),
        .i_code_high  (s_axis_tdata[DATA_W+CODE_HIGH_W-1:DATA_W]),
        .i_data_length(s_axis_tdata[DATA_W+CODE_HIGH_W+LEN_W-1:DATA_W+CODE_HIGH_W]),
        .o_valid      (len_valid),
        .i_ready      (len_ready),
        .o_data       (len_data)
    );

    // Put codeword position 1 at word bit 0
    hsd_align_stage u_align (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(len_valid),
        .o_ready(len_ready),
        .i_data (len_data),
        .o_valid(aln_valid),
        .i_ready(aln_ready),
        .o_data (aln_data)
    );

    // Parity checks, one per power-of-two position, over the positions each one covers
    hsd_syn_stage u_syn (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(aln_valid),
        .o_ready(aln_ready),
        .i_data (aln_data),
        .o_valid(syn_valid),
        .i_ready(syn_ready),
        .o_data (syn_data)
    );

    // Flip the named bit when it lies inside the codeword, then gather data bits
    hsd_fix_stage u_fix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(syn_valid),
        .o_ready(syn_ready),
        .i_data (syn_data),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (res_data)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - DATA_W - SYN_W - ST_W)'(0),
                           res_data.status, res_data.syn, res_data.data};

    // A full pipeline with a stalled output must refuse new transactions
    `HSD_ASSERT(a_full_stall, (len_valid && aln_valid && syn_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "full pipeline still accepts input")
    // The first stage fills only from an accepted input transaction
    `HSD_ASSERT(a_fill_src, $rose(len_valid) |-> $past(s_axis_tvalid && s_axis_tready), "stage one filled without input")
    // Status and syndrome must agree on whether any check failed
    `HSD_ASSERT(a_status_syn, m_axis_tvalid |-> ((m_axis_tdata[72:71] == ST_CLEAN) == (m_axis_tdata[70:64] == 7'd0)), "status disagrees with syndrome")
    // Reset empties the output stage
    `HSD_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule
